// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/pcft_pkg.sv =====
`timescale 1ns / 1ps

package pcft_pkg;

    // Translation table geometry
    localparam int TableDepth = 256;
    localparam int TableAw    = $clog2(TableDepth);
    localparam logic [31:0] TableDepthW = 32'(TableDepth);

    // Operation select codes (mode register); code 15 is unused and passes through
    typedef enum logic [3:0] {
        ModeTrivial   = 4'd0,
        ModeMono      = 4'd1,
        ModeTable     = 4'd2,
        ModeSwap      = 4'd3,
        ModeRgb555    = 4'd4,
        ModeBgr555    = 4'd5,
        ModeRgb565    = 4'd6,
        ModeBgr565    = 4'd7,
        Mode555ToRgb  = 4'd8,
        Mode555ToBgr  = 4'd9,
        Mode565ToRgb  = 4'd10,
        Mode565ToBgr  = 4'd11,
        Mode555To565  = 4'd12,
        Mode565To555  = 4'd13,
        ModeShiftMask = 4'd14
    } t_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CfgMode        = 3'd0,
        CfgRedRotate   = 3'd1,
        CfgGreenRotate = 3'd2,
        CfgBlueRotate  = 3'd3,
        CfgRedMask     = 3'd4,
        CfgGreenMask   = 3'd5,
        CfgBlueMask    = 3'd6,
        CfgTableCount  = 3'd7
    } t_cfg_reg;

    // 5-bit to 8-bit expansion, round(i*255/31) with entry 28 at 231
    localparam logic [7:0] Rom5Tbl [32] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd231, 8'd239, 8'd247, 8'd255
    };

    // 6-bit to 8-bit expansion, round(i*255/63) with entries 13 and 51 adjusted
    localparam logic [7:0] Rom6Tbl [64] = '{
        8'd0,   8'd4,   8'd8,   8'd12,  8'd16,  8'd20,  8'd24,  8'd28,
        8'd32,  8'd36,  8'd40,  8'd45,  8'd49,  8'd52,  8'd57,  8'd61,
        8'd65,  8'd69,  8'd73,  8'd77,  8'd81,  8'd85,  8'd89,  8'd93,
        8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd117, 8'd121, 8'd125,
        8'd130, 8'd134, 8'd138, 8'd142, 8'd146, 8'd150, 8'd154, 8'd158,
        8'd162, 8'd166, 8'd170, 8'd174, 8'd178, 8'd182, 8'd186, 8'd190,
        8'd194, 8'd198, 8'd202, 8'd207, 8'd210, 8'd215, 8'd219, 8'd223,
        8'd227, 8'd231, 8'd235, 8'd239, 8'd243, 8'd247, 8'd251, 8'd255
    };

    function automatic logic [7:0] rom5(input logic [4:0] idx);
        return Rom5Tbl[idx];
    endfunction

    function automatic logic [7:0] rom6(input logic [5:0] idx);
        return Rom6Tbl[idx];
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] wide;
        wide = {x, x} << n;
        return wide[63:32];
    endfunction

endpackage

// ===== rtl/core/pcft_if.sv =====
`timescale 1ns / 1ps

// Pixel request channel
interface pcft_pix_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] pixel_value;
    logic [7:0]  table_index;

    modport source (output valid, output kind, output pixel_value, output table_index,
                    input ready);
    modport sink   (input valid, input kind, input pixel_value, input table_index,
                    output ready);
endinterface

// Result channel
interface pcft_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] translated_color;

    modport source (output valid, output translated_color, input ready);
    modport sink   (input valid, input translated_color, output ready);
endinterface

// Register write channel
interface pcft_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/core/pixel_color_format_translator_core.sv =====
`timescale 1ns / 1ps

// Pixel color format translator. Takes one request per clock on i_pix unless
// the pipe is stalled by o_res: a kind 0 request translates pixel_value by the
// operation in the mode register and returns one translated_color on o_res; a
// kind 1 request stores pixel_value into the 256-word translation table at
// table_index and returns nothing. A translate result passes through stage 1
// (the table read, from the synchronous read port of the table memory) and
// then the output register. Table entries read before they are written
// return undefined data. Registers are written on i_cfg, one per clock; the
// user must write them only while no translate request is in flight, and
// the block itself does not enforce it.
module pixel_color_format_translator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcft_pix_if.sink    i_pix,
    pcft_res_if.source  o_res,
    pcft_cfg_if.sink    i_cfg
);

    // ---------------- configuration registers ----------------
    logic [3:0]  r_mode;
    logic [4:0]  r_red_rotate;
    logic [4:0]  r_green_rotate;
    logic [4:0]  r_blue_rotate;
    logic [31:0] r_red_mask;
    logic [31:0] r_green_mask;
    logic [31:0] r_blue_mask;
    logic [8:0]  r_table_count;

    logic        cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= '0;
            r_red_rotate   <= '0;
            r_green_rotate <= '0;
            r_blue_rotate  <= '0;
            r_red_mask     <= '0;
            r_green_mask   <= '0;
            r_blue_mask    <= '0;
            r_table_count  <= '0;
        end else if (cfg_wr) begin
            case (i_cfg.reg_index)
                pcft_pkg::CfgMode:        r_mode         <= i_cfg.wr_data[3:0];
                pcft_pkg::CfgRedRotate:   r_red_rotate   <= i_cfg.wr_data[4:0];
                pcft_pkg::CfgGreenRotate: r_green_rotate <= i_cfg.wr_data[4:0];
                pcft_pkg::CfgBlueRotate:  r_blue_rotate  <= i_cfg.wr_data[4:0];
                pcft_pkg::CfgRedMask:     r_red_mask     <= i_cfg.wr_data;
                pcft_pkg::CfgGreenMask:   r_green_mask   <= i_cfg.wr_data;
                pcft_pkg::CfgBlueMask:    r_blue_mask    <= i_cfg.wr_data;
                pcft_pkg::CfgTableCount:  r_table_count  <= i_cfg.wr_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- request handshake ----------------
    // Stage 1 holds an accepted translate request together with the table
    // word read for it; the output register holds the finished result.
    logic        r_s1_valid;
    logic [31:0] r_s1_pixel;
    logic        r_out_valid;
    logic [31:0] r_out_color;
    logic [31:0] n_out_color;

    logic        s1_adv;
    logic        pix_acc;
    logic        xlate_acc;
    logic        tbl_wr;

    assign s1_adv      = r_s1_valid & (~r_out_valid | o_res.ready);
    assign i_pix.ready = ~r_s1_valid | s1_adv;
    assign pix_acc     = i_pix.valid & i_pix.ready;
    assign xlate_acc   = pix_acc & ~i_pix.kind;

    // ---------------- translation table ----------------
    logic [31:0] r_table [pcft_pkg::TableDepth];
    logic [31:0] r_rd_data;
    logic [31:0] wr_idx_ext;
    logic [pcft_pkg::TableAw-1:0] rd_addr;

    assign wr_idx_ext = 32'(i_pix.table_index);
    // writes beyond the table depth are dropped
    assign tbl_wr     = pix_acc & i_pix.kind & (wr_idx_ext < pcft_pkg::TableDepthW);
    // mono compares against entry 0, lookup reads the entry the pixel names
    assign rd_addr    = (r_mode == pcft_pkg::ModeMono) ? '0
                                                       : i_pix.pixel_value[pcft_pkg::TableAw-1:0];

    always_ff @(posedge i_clk) begin
        if (tbl_wr) begin
            r_table[wr_idx_ext[pcft_pkg::TableAw-1:0]] <= i_pix.pixel_value;
        end
        if (xlate_acc) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (xlate_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xlate_acc) begin
            r_s1_pixel <= i_pix.pixel_value;
        end
    end

    // ---------------- translate ----------------
    logic [31:0] c;
    logic        tbl_hit;
    logic [7:0]  lo5_555;
    logic [7:0]  g_555;
    logic [7:0]  hi5_555;
    logic [7:0]  lo5_565;
    logic [7:0]  g_565;
    logic [7:0]  hi5_565;

    assign c = r_s1_pixel;
    // lookup answers 0 past the valid count or past the table depth
    assign tbl_hit = (c < {23'b0, r_table_count}) & (c < pcft_pkg::TableDepthW);

    assign lo5_555 = pcft_pkg::rom5(c[4:0]);
    assign g_555   = pcft_pkg::rom5(c[9:5]);
    assign hi5_555 = pcft_pkg::rom5(c[14:10]);
    assign lo5_565 = lo5_555;
    assign g_565   = pcft_pkg::rom6(c[10:5]);
    assign hi5_565 = pcft_pkg::rom5(c[15:11]);

    always_comb begin
        case (r_mode)
            pcft_pkg::ModeTrivial:   n_out_color = c;
            pcft_pkg::ModeMono:      n_out_color = {31'b0, (c == r_rd_data)};
            pcft_pkg::ModeTable:     n_out_color = tbl_hit ? r_rd_data : '0;
            pcft_pkg::ModeSwap:      n_out_color = {c[31:24], c[7:0], c[15:8], c[23:16]};
            pcft_pkg::ModeRgb555:    n_out_color = {17'b0, c[7:3], c[15:11], c[23:19]};
            pcft_pkg::ModeBgr555:    n_out_color = {17'b0, c[23:19], c[15:11], c[7:3]};
            pcft_pkg::ModeRgb565:    n_out_color = {16'b0, c[7:3], c[15:10], c[23:19]};
            pcft_pkg::ModeBgr565:    n_out_color = {16'b0, c[23:19], c[15:10], c[7:3]};
            pcft_pkg::Mode555ToRgb:  n_out_color = {8'b0, lo5_555, g_555, hi5_555};
            pcft_pkg::Mode555ToBgr:  n_out_color = {8'b0, hi5_555, g_555, lo5_555};
            pcft_pkg::Mode565ToRgb:  n_out_color = {8'b0, lo5_565, g_565, hi5_565};
            pcft_pkg::Mode565ToBgr:  n_out_color = {8'b0, hi5_565, g_565, lo5_565};
            // top green bit is copied into the new green LSB
            pcft_pkg::Mode555To565:  n_out_color = {16'b0, c[14:5], c[9], c[4:0]};
            pcft_pkg::Mode565To555:  n_out_color = {17'b0, c[15:6], c[4:0]};
            pcft_pkg::ModeShiftMask: begin
                n_out_color = (pcft_pkg::rotl32(c, r_red_rotate)   & r_red_mask)
                            | (pcft_pkg::rotl32(c, r_green_rotate) & r_green_mask)
                            | (pcft_pkg::rotl32(c, r_blue_rotate)  & r_blue_mask);
            end
            default:                 n_out_color = c;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_color <= n_out_color;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.translated_color = r_out_color;

endmodule

// ===== rtl/core/pcft_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_kind,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);

    // a stalled result stays and keeps its value
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // with the output register empty nothing blocks the input side
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // a fresh result comes from an earlier accepted translate request
    `ASSERT_IMPL(a_result_source, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready && !i_in_kind, 2))

endmodule

bind pixel_color_format_translator_core pcft_checker u_pcft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_kind   (i_pix.kind),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.translated_color)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Request kinds on the pixel channel
    localparam logic KindTranslate  = 1'b0;
    localparam logic KindTableWrite = 1'b1;

    // Mode code 15 has no name in the package; it must pass pixels through
    localparam logic [3:0] ModeUnused = 4'hF;

    // Expansion ROM entries that do not follow plain rounding
    localparam logic [4:0] Lvl5OddIdx  = 5'd28;
    localparam logic [7:0] Lvl5OddVal  = 8'd231;
    localparam logic [5:0] Lvl6OddIdxA = 6'd13;
    localparam logic [7:0] Lvl6OddValA = 8'd52;
    localparam logic [5:0] Lvl6OddIdxB = 6'd51;
    localparam logic [7:0] Lvl6OddValB = 8'd207;

    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
    localparam int ROUNDS       = 24;
    localparam int ROUND_ITEMS  = 66;
    localparam int BURST_ROUND  = 18;    // inside the no-idle stretch
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic        kind;
        logic [31:0] pixel;
        logic [7:0]  index;
    } t_pix_req;

    logic i_clk;
    logic i_rst_n;

    pcft_pix_if pix_ch ();
    pcft_res_if res_ch ();
    pcft_cfg_if cfg_ch ();

    pixel_color_format_translator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    t_pix_req    pixel_reqs[$];     // requests waiting for the driver
    logic [31:0] color_expect[$];   // predicted colors, oldest first
    int unsigned reqs_queued;       // requests ever handed to the driver
    int unsigned pix_taken;         // requests accepted by the block
    int unsigned fail_count;
    int unsigned quiet_cycles;
    int          sender_gap_pct;
    int          sink_stall_pct;
    logic        res_hold;
    logic        burst_armed;
    t_pix_req    drv_req;

    // Predictor copy of registers and table, updated on accepted requests
    logic [3:0]  cur_mode;
    logic [4:0]  cur_red_rot, cur_green_rot, cur_blue_rot;
    logic [31:0] cur_red_mask, cur_green_mask, cur_blue_mask;
    logic [8:0]  cur_count;
    logic [31:0] xlat_table [256];

    // Generator bookkeeping: what it has already asked for, so that no
    // request ever reads a table entry that was never written
    logic [3:0]  plan_mode;
    logic [8:0]  plan_count;
    logic [31:0] plan_entry0;
    bit          plan_written [256];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // 5-bit channel to 8 bits: round(i*255/31), one entry nudged up
    function automatic logic [7:0] level5(input logic [4:0] i);
        if (i == Lvl5OddIdx) return Lvl5OddVal;
        return 8'((int'(i) * 510 + 31) / 62);
    endfunction

    // 6-bit channel to 8 bits: round(i*255/63), two entries nudged
    function automatic logic [7:0] level6(input logic [5:0] i);
        if (i == Lvl6OddIdxA) return Lvl6OddValA;
        if (i == Lvl6OddIdxB) return Lvl6OddValB;
        return 8'((int'(i) * 510 + 63) / 126);
    endfunction

    function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] n);
        if (n == 5'd0) return x;
        return (x << n) | (x >> (6'd32 - n));
    endfunction

    function automatic logic [31:0] translate_pixel(input logic [31:0] c);
        logic [8:0] lim;
        lim = (cur_count > 9'd256) ? 9'd256 : cur_count;
        case (cur_mode)
            pcft_pkg::ModeTrivial:   return c;
            pcft_pkg::ModeMono:      return (c == xlat_table[0]) ? 32'd1 : 32'd0;
            pcft_pkg::ModeTable:     return (c >= 32'(lim)) ? 32'd0 : xlat_table[c[7:0]];
            pcft_pkg::ModeSwap:      return {c[31:24], c[7:0], c[15:8], c[23:16]};
            pcft_pkg::ModeRgb555:    return {17'd0, c[7:3], c[15:11], c[23:19]};
            pcft_pkg::ModeBgr555:    return {17'd0, c[23:19], c[15:11], c[7:3]};
            pcft_pkg::ModeRgb565:    return {16'd0, c[7:3], c[15:10], c[23:19]};
            pcft_pkg::ModeBgr565:    return {16'd0, c[23:19], c[15:10], c[7:3]};
            // 16-bit expansions: blue field is bits 4:0, red the top field;
            // the RGB variants put red in the low byte
            pcft_pkg::Mode555ToRgb:
                return {8'd0, level5(c[4:0]), level5(c[9:5]), level5(c[14:10])};
            pcft_pkg::Mode555ToBgr:
                return {8'd0, level5(c[14:10]), level5(c[9:5]), level5(c[4:0])};
            pcft_pkg::Mode565ToRgb:
                return {8'd0, level5(c[4:0]), level6(c[10:5]), level5(c[15:11])};
            pcft_pkg::Mode565ToBgr:
                return {8'd0, level5(c[15:11]), level6(c[10:5]), level5(c[4:0])};
            // green LSB in 565 copies the top green bit of the 555 source
            pcft_pkg::Mode555To565:  return {16'd0, c[14:5], c[9], c[4:0]};
            pcft_pkg::Mode565To555:  return {17'd0, c[15:6], c[4:0]};
            pcft_pkg::ModeShiftMask: return (rot_left(c, cur_red_rot) & cur_red_mask)
                                          | (rot_left(c, cur_green_rot) & cur_green_mask)
                                          | (rot_left(c, cur_blue_rot) & cur_blue_mask);
            default:                 return c;
        endcase
    endfunction

    function automatic void apply_reg_write(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            pcft_pkg::CfgMode:        cur_mode       = data[3:0];
            pcft_pkg::CfgRedRotate:   cur_red_rot    = data[4:0];
            pcft_pkg::CfgGreenRotate: cur_green_rot  = data[4:0];
            pcft_pkg::CfgBlueRotate:  cur_blue_rot   = data[4:0];
            pcft_pkg::CfgRedMask:     cur_red_mask   = data;
            pcft_pkg::CfgGreenMask:   cur_green_mask = data;
            pcft_pkg::CfgBlueMask:    cur_blue_mask  = data;
            pcft_pkg::CfgTableCount:  cur_count      = data[8:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Pixel driver: pops the next request once the current one is taken.
    // Gaps are rolled per cycle against sender_gap_pct.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (!pix_ch.valid || pix_ch.ready) begin
            if (pixel_reqs.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                drv_req = pixel_reqs.pop_front();
                pix_ch.valid       <= 1'b1;
                pix_ch.kind        <= drv_req.kind;
                pix_ch.pixel_value <= drv_req.pixel;
                pix_ch.table_index <= drv_req.index;
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls, plus the long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !res_hold && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: register writes and table writes update the predictor,
    // translate requests queue a predicted color, results are compared
    // against the oldest prediction. Results are checked before new
    // predictions are pushed so a premature output cannot match.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (color_expect.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("[%0t] unexpected result 0x%08h", $realtime,
                                 res_ch.translated_color);
                    fail_count++;
                end else if (res_ch.translated_color !== color_expect[0]) begin
                    if (fail_count < REPORT_MAX)
                        $display("[%0t] translated_color mismatch: expected 0x%08h got 0x%08h",
                                 $realtime, color_expect[0], res_ch.translated_color);
                    fail_count++;
                    void'(color_expect.pop_front());
                end else begin
                    void'(color_expect.pop_front());
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                apply_reg_write(cfg_ch.reg_index, cfg_ch.wr_data);
            if (pix_ch.valid && pix_ch.ready) begin
                pix_taken++;
                if (pix_ch.kind == KindTableWrite)
                    xlat_table[pix_ch.table_index] = pix_ch.pixel_value;
                else
                    color_expect.push_back(translate_pixel(pix_ch.pixel_value));
            end
        end
    end

    // Watchdog: too long without any request, result or register write moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Long sink hold-off: the sender keeps streaming, so the pipe fills
    // and the block has to drop its input ready
    initial begin
        res_hold = 1'b0;
        wait (burst_armed);
        @(posedge i_clk);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Block is idle once every request is taken and every color returned;
    // table writes give no result, so allow the pipe depth on top
    task automatic wait_idle();
        while (pix_taken != reqs_queued || color_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input pcft_pkg::t_cfg_reg idx, input logic [31:0] data);
        wait_idle();
        @(posedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == pcft_pkg::CfgMode) plan_mode = data[3:0];
        if (idx == pcft_pkg::CfgTableCount) plan_count = data[8:0];
    endtask

    task automatic push_req(input logic kind, input logic [31:0] pixel,
                            input logic [7:0] index);
        t_pix_req r;
        r.kind  = kind;
        r.pixel = pixel;
        r.index = index;
        if (kind == KindTableWrite) begin
            plan_written[index] = 1'b1;
            if (index == 8'd0) plan_entry0 = pixel;
        end
        pixel_reqs.push_back(r);
        reqs_queued++;
    endtask

    function automatic logic [31:0] pick_edge_value();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One translate request shaped for the current mode
    task automatic push_pixel();
        logic [31:0] px;
        logic [8:0]  lim;
        int unsigned roll;
        roll = $urandom_range(99);
        lim  = (plan_count > 9'd256) ? 9'd256 : plan_count;
        if (plan_mode == pcft_pkg::ModeTable) begin
            // mostly near the table, with the count boundary hit often
            if (roll < 60)      px = $urandom_range(0, 300);
            else if (roll < 70) px = (lim == 0) ? 32'd0 : 32'(lim) - 1;
            else if (roll < 80) px = 32'(lim);
            else                px = $urandom;
            if (px < 32'(lim) && !plan_written[px[7:0]])
                push_req(KindTableWrite, $urandom, px[7:0]);
        end else if (plan_mode == pcft_pkg::ModeMono) begin
            px = (roll < 40) ? plan_entry0 : ((roll < 50) ? ~plan_entry0 : $urandom);
        end else begin
            px = (roll < 16) ? pick_edge_value() : $urandom;
        end
        push_req(KindTranslate, px, 8'($urandom));
    endtask

    function automatic logic [4:0] pick_rotate();
        case ($urandom_range(3))
            0:       return 5'd0;
            1:       return 5'd31;
            default: return 5'($urandom);
        endcase
    endfunction

    function automatic logic [8:0] pick_count();
        case ($urandom_range(7))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'd511;
            3:       return 9'd1;
            4:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(2, 255));
        endcase
    endfunction

    task automatic randomize_config();
        write_reg(pcft_pkg::CfgRedRotate,   32'(pick_rotate()));
        write_reg(pcft_pkg::CfgGreenRotate, 32'(pick_rotate()));
        write_reg(pcft_pkg::CfgBlueRotate,  32'(pick_rotate()));
        write_reg(pcft_pkg::CfgRedMask,     pick_edge_value());
        write_reg(pcft_pkg::CfgGreenMask,   pick_edge_value());
        write_reg(pcft_pkg::CfgBlueMask,    pick_edge_value());
        write_reg(pcft_pkg::CfgTableCount,  32'(pick_count()));
        write_reg(pcft_pkg::CfgMode,        32'($urandom_range(0, 15)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] seed0;
        i_rst_n            = 1'b0;
        pix_ch.valid       = 1'b0;
        pix_ch.kind        = KindTranslate;
        pix_ch.pixel_value = '0;
        pix_ch.table_index = '0;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = pcft_pkg::CfgMode;
        cfg_ch.wr_data     = '0;
        burst_armed        = 1'b0;
        reqs_queued        = 0;
        pix_taken          = 0;
        fail_count         = 0;
        sender_gap_pct     = 9;
        sink_stall_pct     = 87;
        // predictor and planner start from the reset register values
        cur_mode = '0; cur_red_rot = '0; cur_green_rot = '0; cur_blue_rot = '0;
        cur_red_mask = '0; cur_green_mask = '0; cur_blue_mask = '0; cur_count = '0;
        plan_mode = '0; plan_count = '0; plan_entry0 = '0;
        for (int i = 0; i < 256; i++) begin
            xlat_table[i]   = '0;
            plan_written[i] = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- Directed part ---
        // seed entry 0 (mono compare), entry 1 all ones, last entry random
        seed0 = $urandom;
        push_req(KindTableWrite, seed0, 8'd0);
        push_req(KindTableWrite, 32'hFFFF_FFFF, 8'd1);
        push_req(KindTableWrite, $urandom, 8'd255);

        write_reg(pcft_pkg::CfgMode, 32'(pcft_pkg::ModeTrivial));
        push_req(KindTranslate, 32'hFFFF_FFFF, 8'hFF);
        push_req(KindTranslate, 32'd0, 8'h00);

        // mono: one equal to entry 0, one that differs
        write_reg(pcft_pkg::CfgMode, 32'(pcft_pkg::ModeMono));
        push_req(KindTranslate, seed0, 8'h00);
        push_req(KindTranslate, ~seed0, 8'h00);

        // table lookup: a hit, index at the count, index far out of range
        write_reg(pcft_pkg::CfgTableCount, 32'd2);
        write_reg(pcft_pkg::CfgMode, 32'(pcft_pkg::ModeTable));
        push_req(KindTranslate, 32'd1, 8'h00);
        push_req(KindTranslate, 32'd2, 8'h00);
        push_req(KindTranslate, 32'hFFFF_FFFF, 8'h00);
        // oversized count clamps to the table depth
        write_reg(pcft_pkg::CfgTableCount, 32'd511);
        push_req(KindTranslate, 32'd255, 8'h00);
        push_req(KindTranslate, 32'd256, 8'h00);

        write_reg(pcft_pkg::CfgMode, 32'(pcft_pkg::ModeSwap));
        push_req(KindTranslate, $urandom, 8'h00);

        // packing, expansion and 555/565 conversions; upper bits set
        // so that ignored source bits are exercised
        for (int m = pcft_pkg::ModeRgb555; m <= pcft_pkg::Mode565To555; m++) begin
            write_reg(pcft_pkg::CfgMode, 32'(m));
            push_req(KindTranslate, m[0] ? $urandom : 32'hFFFF_FFFF, 8'h00);
        end

        // shift-mask with zero rotates is a masked pass-through
        write_reg(pcft_pkg::CfgRedRotate, 32'd0);
        write_reg(pcft_pkg::CfgGreenRotate, 32'd0);
        write_reg(pcft_pkg::CfgBlueRotate, 32'd0);
        write_reg(pcft_pkg::CfgRedMask, 32'hFFFF_FFFF);
        write_reg(pcft_pkg::CfgGreenMask, 32'd0);
        write_reg(pcft_pkg::CfgBlueMask, 32'd0);
        write_reg(pcft_pkg::CfgMode, 32'(pcft_pkg::ModeShiftMask));
        push_req(KindTranslate, $urandom, 8'h00);
        write_reg(pcft_pkg::CfgRedRotate, 32'd31);
        write_reg(pcft_pkg::CfgGreenRotate, 32'd1);
        write_reg(pcft_pkg::CfgBlueRotate, 32'd16);
        write_reg(pcft_pkg::CfgRedMask, 32'hFF00_FF00);
        write_reg(pcft_pkg::CfgGreenMask, 32'h00FF_00FF);
        write_reg(pcft_pkg::CfgBlueMask, 32'h0F0F_0F0F);
        push_req(KindTranslate, $urandom, 8'h00);

        write_reg(pcft_pkg::CfgMode, 32'(ModeUnused));
        push_req(KindTranslate, $urandom, 8'h00);

        // --- Random rounds ---
        // thirds: sink-heavy stalls, sender-heavy gaps, then full rate
        for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            wait_idle();
            if (rnd < ROUNDS / 3) begin
                sender_gap_pct = 9;
                sink_stall_pct = 87;
            end else if (rnd < 2 * ROUNDS / 3) begin
                sender_gap_pct = 87;
                sink_stall_pct = 9;
            end else begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end
            randomize_config();
            for (int k = 0; k < ROUND_ITEMS; k++) begin
                if ($urandom_range(99) < 15)
                    push_req(KindTableWrite, $urandom, 8'($urandom));
                else
                    push_pixel();
            end
            if (rnd == BURST_ROUND) burst_armed = 1'b1;
        end

        wait_idle();
        if (fail_count == 0 && color_expect.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
